>>> design/tsplf_pkg.sv
// Shared types, constants and coefficient decode for the four-tap sub-pel luma filter.
package tsplf_pkg;

    localparam int PIX_W       = 8;
    localparam int MAX_LANES   = 8;
    localparam int WORD_W      = PIX_W * MAX_LANES;
    localparam int LANES_DFLT  = 8;
    localparam int COEF_W      = 7;
    localparam int SUM_W       = 16;
    localparam int ROUND_OFS   = 16;
    localparam int ROUND_SHIFT = 5;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 1;
    localparam int FRAC_W      = 2;

    localparam logic [REG_IDX_W-1:0] REG_FRAC_POSITION = 1'b0;

    localparam logic [FRAC_W-1:0] FRAC_FULL    = 2'd0;
    localparam logic [FRAC_W-1:0] FRAC_QUARTER = 2'd1;
    localparam logic [FRAC_W-1:0] FRAC_HALF    = 2'd2;
    localparam logic [FRAC_W-1:0] FRAC_THREEQ  = 2'd3;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] c_before;
        logic signed [COEF_W-1:0] c_center;
        logic signed [COEF_W-1:0] c_after;
        logic signed [COEF_W-1:0] c_after_two;
    } coef_set_t;

    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } queue_status_t;

    function automatic coef_set_t coef_for(input logic [FRAC_W-1:0] frac);
        coef_set_t c;
        unique case (frac)
            FRAC_FULL:    c = '{7'sd0,  7'sd32, 7'sd0,  7'sd0};
            FRAC_QUARTER: c = '{-7'sd1, 7'sd25, 7'sd9,  -7'sd1};
            FRAC_HALF:    c = '{-7'sd2, 7'sd18, 7'sd18, -7'sd2};
            FRAC_THREEQ:  c = '{-7'sd1, 7'sd9,  7'sd25, -7'sd1};
            default:      c = '{7'sd0,  7'sd32, 7'sd0,  7'sd0};
        endcase
        return c;
    endfunction

endpackage

>>> design/tsplf_lane.sv
// One filter lane: four-tap weighted sum, rounding shift and clip to 0..255.
module tsplf_lane
    import tsplf_pkg::*;
(
    input  coef_set_t coef,
    input  pixel_t    px_before,
    input  pixel_t    px_center,
    input  pixel_t    px_after,
    input  pixel_t    px_after_two,
    output pixel_t    px_out
);

    logic signed [SUM_W-1:0] prod_before;
    logic signed [SUM_W-1:0] prod_center;
    logic signed [SUM_W-1:0] prod_after;
    logic signed [SUM_W-1:0] prod_after_two;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] scaled;

    // widen both operands first so the product keeps its full range
    assign prod_before    = SUM_W'(coef.c_before)    * SUM_W'($signed({1'b0, px_before}));
    assign prod_center    = SUM_W'(coef.c_center)    * SUM_W'($signed({1'b0, px_center}));
    assign prod_after     = SUM_W'(coef.c_after)     * SUM_W'($signed({1'b0, px_after}));
    assign prod_after_two = SUM_W'(coef.c_after_two) * SUM_W'($signed({1'b0, px_after_two}));

    assign sum    = prod_before + prod_center + prod_after + prod_after_two
                  + SUM_W'(ROUND_OFS);
    assign scaled = sum >>> ROUND_SHIFT;

    // clip: negative goes to zero, anything past the pixel range to full scale
    always_comb begin
        if (scaled < 0) begin
            px_out = '0;
        end else if (scaled > SUM_W'(2**PIX_W - 1)) begin
            px_out = '1;
        end else begin
            px_out = scaled[PIX_W-1:0];
        end
    end

endmodule

>>> design/tsplf_merge.sv
// Merge stage: packs lane results into one word and buffers it in an output register plus skid slot.
module tsplf_merge
    import tsplf_pkg::*;
#(
    parameter int LANES = LANES_DFLT
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  pixel_t              lane_px [LANES],
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [WORD_W-1:0]   out_word,
    output queue_status_t       status
);

    logic [WORD_W-1:0] packed_word;
    logic [WORD_W-1:0] main_data_reg;
    logic [WORD_W-1:0] skid_data_reg;
    logic              main_valid_reg;
    logic              skid_valid_reg;
    logic              accept_in;
    logic              accept_out;

    genvar i;
    generate
        for (i = 0; i < MAX_LANES; i++) begin : g_pack
            if (i < LANES) begin : g_used
                assign packed_word[i*PIX_W +: PIX_W] = lane_px[i];
            end else begin : g_unused
                assign packed_word[i*PIX_W +: PIX_W] = '0;
            end
        end
    endgenerate

    assign in_ready   = !skid_valid_reg;
    assign accept_in  = in_valid && in_ready;
    assign accept_out = main_valid_reg && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (accept_out || !main_valid_reg) begin
            // refill the output register, skid item first
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= accept_in;
            end
        end else if (accept_in) begin
            // output stalled: park the item in the skid slot
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_out || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_data_reg <= skid_data_reg;
            end else if (accept_in) begin
                main_data_reg <= packed_word;
            end
        end else if (accept_in) begin
            skid_data_reg <= packed_word;
        end
    end

    assign out_valid         = main_valid_reg;
    assign out_word          = main_data_reg;
    assign status.main_valid = main_valid_reg;
    assign status.skid_valid = skid_valid_reg;

endmodule

>>> design/four_tap_subpel_luma_filter.sv
// Four-tap sub-pel luma filter top level: config register, filter lanes and merge stage.
// All lanes filter in parallel in one combinational pass; each result is then registered.
// Throughput: one item per cycle, while s_ready is high (skid slot free).
// A two-entry output buffer keeps accepting while one result waits to be taken.
// Reset (aresetn low, synchronous): buffer emptied, frac_position back to quarter (1).
module four_tap_subpel_luma_filter
    import tsplf_pkg::*;
#(
    parameter int LANES = LANES_DFLT
)
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [WORD_W-1:0]     s_tap_before,
    input  logic [WORD_W-1:0]     s_tap_center,
    input  logic [WORD_W-1:0]     s_tap_after,
    input  logic [WORD_W-1:0]     s_tap_after_two,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [WORD_W-1:0]     m_filtered_pixels
);

    logic [FRAC_W-1:0]    frac_position_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    coef_set_t            coef;
    pixel_t               lane_px [LANES];
    queue_status_t        q_status;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1 -: REG_IDX_W];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_position_reg <= FRAC_QUARTER;
        end else if (cfg_write && reg_idx == REG_FRAC_POSITION) begin
            frac_position_reg <= pwdata[FRAC_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAC_POSITION: prdata = APB_DATA_W'(frac_position_reg);
            default:           prdata = '0;
        endcase
    end

    assign coef = coef_for(frac_position_reg);

    genvar i;
    generate
        for (i = 0; i < LANES; i++) begin : g_lane
            tsplf_lane u_lane (
                .coef         (coef),
                .px_before    (s_tap_before[i*PIX_W +: PIX_W]),
                .px_center    (s_tap_center[i*PIX_W +: PIX_W]),
                .px_after     (s_tap_after[i*PIX_W +: PIX_W]),
                .px_after_two (s_tap_after_two[i*PIX_W +: PIX_W]),
                .px_out       (lane_px[i])
            );
        end
    endgenerate

    tsplf_merge #(
        .LANES (LANES)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lane_px   (lane_px),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (m_filtered_pixels),
        .status    (q_status)
    );

    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.skid_valid |-> q_status.main_valid)
        else $error("skid slot holds an item while the output register is empty");

    a_item_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !m_valid) |=> m_valid)
        else $error("accepted item did not reach the output register");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && m_valid && !m_ready) |=> q_status.skid_valid)
        else $error("item accepted under stall was not parked");

    a_cfg_write_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_write && reg_idx == REG_FRAC_POSITION)
            |=> frac_position_reg == $past(pwdata[FRAC_W-1:0]))
        else $error("frac_position write was lost");

endmodule
